/* sv/pett_pkg.sv */
// Shared types and constants for the periodic event timer table.
// Depends on nothing; used by the controller, the datapath and the top level.
package pett_pkg;

  // operation codes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_ADD        = 3'd1;
  localparam logic [2:0] OP_REMOVE_ONE = 3'd2;
  localparam logic [2:0] OP_REMOVE_OBJ = 3'd3;
  localparam logic [2:0] OP_REMOVE_ALL = 3'd4;

  // report kinds
  localparam logic [1:0] RK_FIRED = 2'd0;
  localparam logic [1:0] RK_ADDED = 2'd1;
  localparam logic [1:0] RK_FULL  = 2'd2;

  // fire reports per tick are capped
  localparam int MAX_REPORTS = 16;
  localparam int REP_W       = 5;

  // controller -> datapath
  typedef struct packed {
    logic load;       // item accepted this cycle
    logic rm_one;     // remove the selected slot
    logic rm_all;     // remove every slot
    logic rd_en;      // scan read issued at addr
    logic scan_tick;  // scan belongs to a tick (else remove by object)
    logic flush;      // push out the held fire report as the last one
    logic add_try;    // test slot at addr for an add
    logic add_last;   // addr is the final slot
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;  // slot at addr is not live
  } status_t;

endpackage

/* sv/pett_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pett_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/pett_ctrl.sv */
// Controller for the timer table: sequences ticks, adds and removes.
// Depends on pett_pkg; drives the datapath through cmd_t and reads status_t.
module pett_ctrl import pett_pkg::*; #(
  parameter int SLOTS = 16,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       operation,
  input  status_t          status,
  output logic             busy,
  output cmd_t             cmd,
  output logic [IDX_W-1:0] addr
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_RMOBJ,
    S_ADD,
    S_FLUSH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             scan_end;

  assign accept   = start && (state == S_IDLE);
  assign scan_end = (cnt == CNT_W'(SLOTS));
  assign busy     = (state != S_IDLE);
  assign addr     = cnt[IDX_W-1:0];

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.rm_one    = accept && (operation == OP_REMOVE_ONE);
    cmd.rm_all    = accept && (operation == OP_REMOVE_ALL);
    cmd.rd_en     = ((state == S_TICK) || (state == S_RMOBJ)) && !scan_end;
    cmd.scan_tick = (state == S_TICK);
    cmd.flush     = (state == S_FLUSH);
    cmd.add_try   = (state == S_ADD);
    cmd.add_last  = (cnt == CNT_W'(SLOTS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start) begin
            case (operation)
              OP_TICK:       state <= S_TICK;
              OP_ADD:        state <= S_ADD;
              OP_REMOVE_OBJ: state <= S_RMOBJ;
              default:       state <= S_IDLE;
            endcase
          end
        end
        S_TICK: begin
          cnt <= cnt + 1'b1;
          if (scan_end) begin
            state <= S_FLUSH;
          end
        end
        S_RMOBJ: begin
          cnt <= cnt + 1'b1;
          if (scan_end) begin
            state <= S_IDLE;
          end
        end
        S_ADD: begin
          cnt <= cnt + 1'b1;
          if (status.slot_free || cmd.add_last) begin
            state <= S_IDLE;
          end
        end
        S_FLUSH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/pett_dp.sv */
// Datapath for the timer table: live bits, slot memories, accumulator update
// and the report registers. Depends on pett_pkg and pett_ram.
module pett_dp import pett_pkg::*; #(
  parameter int SLOTS      = 16,
  parameter int COUNT_BITS = 16,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [IDX_W-1:0] addr,
  output status_t          status,
  input  logic [15:0]      period,
  input  logic [15:0]      lifetime,
  input  logic [7:0]       action_code,
  input  logic [7:0]       object_tag,
  input  logic [2:0]       object_kind,
  input  logic             fire_at_once,
  input  logic [3:0]       slot_select,
  output logic             strobe,
  output logic [1:0]       report_kind,
  output logic [3:0]       slot_id,
  output logic [7:0]       fired_action,
  output logic [7:0]       fired_object,
  output logic [2:0]       fired_kind,
  output logic             expired,
  output logic             last
);

  localparam int CB     = COUNT_BITS;
  localparam int AB     = COUNT_BITS + 1;
  localparam int STAT_W = 2 * CB + 19;
  localparam int ACC_W  = 2 * AB;

  // latched item
  logic [CB-1:0] a_period, a_life;
  logic [7:0]    a_action, a_object;
  logic [2:0]    a_kind;
  logic          a_fire;

  logic [SLOTS-1:0] live;

  // scan eval stage, aligned with registered RAM data
  logic             ev_valid, ev_tick;
  logic [IDX_W-1:0] ev_idx;

  logic [STAT_W-1:0] stat_rd, stat_wr;
  logic [ACC_W-1:0]  acc_rd, acc_wr;
  logic              acc_we, add_wr;
  logic [IDX_W-1:0]  acc_waddr;

  logic [CB-1:0] r_period, r_life;
  logic [7:0]    r_action, r_object;
  logic [2:0]    r_kind;
  logic [AB-1:0] r_pc, r_lc, pc_inc, lc_inc, pc_new;
  logic          ev_live, fire, gone, obj_hit, tick_wr, rep_ok;

  // held fire report
  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;
  logic [7:0]       pend_action, pend_object;
  logic [2:0]       pend_kind;
  logic             pend_exp;
  logic [REP_W-1:0] rep_cnt;

  logic [IDX_W-1:0] sel_idx;
  logic             sel_ok;
  logic [AB-1:0]    preset_pc, preset_lc;

  assign status.slot_free = !live[addr];
  assign add_wr           = cmd.add_try && status.slot_free;

  assign sel_idx = IDX_W'(slot_select);
  assign sel_ok  = (32'(slot_select) < SLOTS);

  assign {r_period, r_life, r_action, r_object, r_kind} = stat_rd;
  assign {r_pc, r_lc} = acc_rd;

  // saturating accumulator step
  assign pc_inc  = (&r_pc) ? r_pc : r_pc + 1'b1;
  assign lc_inc  = (r_life == '0) ? r_lc : ((&r_lc) ? r_lc : r_lc + 1'b1);
  assign ev_live = ev_valid && live[ev_idx];
  assign fire    = (pc_inc >= {1'b0, r_period});
  assign gone    = fire && (r_life != '0) && (lc_inc >= {1'b0, r_life});
  assign pc_new  = fire ? '0 : pc_inc;
  assign tick_wr = ev_live && ev_tick;
  assign obj_hit = ev_live && !ev_tick && (r_object == a_object) && (r_action == a_action);
  assign rep_ok  = (rep_cnt < REP_W'(MAX_REPORTS));

  // add: fire at once presets pc (and lc, if lifetime set) to the period
  assign preset_pc = a_fire ? {1'b0, a_period} : '0;
  assign preset_lc = (a_fire && (a_life != '0)) ? {1'b0, a_period} : '0;

  assign stat_wr   = {a_period, a_life, a_action, a_object, a_kind};
  assign acc_we    = add_wr || tick_wr;
  assign acc_waddr = add_wr ? addr : ev_idx;
  assign acc_wr    = add_wr ? {preset_pc, preset_lc} : {pc_new, lc_inc};

  pett_ram #(.WIDTH(STAT_W), .DEPTH(SLOTS)) u_stat_ram (
    .clk     (clk),
    .wr_en   (add_wr),
    .wr_addr (addr),
    .wr_data (stat_wr),
    .rd_addr (addr),
    .rd_data (stat_rd)
  );

  pett_ram #(.WIDTH(ACC_W), .DEPTH(SLOTS)) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_we),
    .wr_addr (acc_waddr),
    .wr_data (acc_wr),
    .rd_addr (addr),
    .rd_data (acc_rd)
  );

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_period <= CB'(period);
      a_life   <= CB'(lifetime);
      a_action <= action_code;
      a_object <= object_tag;
      a_kind   <= object_kind;
      a_fire   <= fire_at_once;
    end
  end

  // eval stage tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= cmd.rd_en;
    end
    ev_tick <= cmd.scan_tick;
    ev_idx  <= addr;
  end

  // live bits
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (cmd.rm_all) begin
      live <= '0;
    end else if (cmd.rm_one) begin
      if (sel_ok) begin
        live[sel_idx] <= 1'b0;
      end
    end else if (add_wr) begin
      live[addr] <= 1'b1;
    end else if ((tick_wr && gone) || obj_hit) begin
      live[ev_idx] <= 1'b0;
    end
  end

  // reports
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      rep_cnt    <= '0;
    end else begin
      strobe <= 1'b0;
      if (cmd.load) begin
        pend_valid <= 1'b0;
        rep_cnt    <= '0;
      end
      if (tick_wr && fire && rep_ok) begin
        rep_cnt    <= rep_cnt + 1'b1;
        pend_valid <= 1'b1;
        strobe     <= pend_valid;
      end
      if (cmd.flush && pend_valid) begin
        pend_valid <= 1'b0;
        strobe     <= 1'b1;
      end
      if (cmd.add_try && (status.slot_free || cmd.add_last)) begin
        strobe <= 1'b1;
      end
    end

    // payload
    if (tick_wr && fire && rep_ok) begin
      pend_idx    <= ev_idx;
      pend_action <= r_action;
      pend_object <= r_object;
      pend_kind   <= r_kind;
      pend_exp    <= gone;
    end
    if ((tick_wr && fire && rep_ok) || cmd.flush) begin
      report_kind  <= RK_FIRED;
      slot_id      <= 4'(pend_idx);
      fired_action <= pend_action;
      fired_object <= pend_object;
      fired_kind   <= pend_kind;
      expired      <= pend_exp;
      last         <= cmd.flush;
    end else if (cmd.add_try) begin
      report_kind  <= status.slot_free ? RK_ADDED : RK_FULL;
      slot_id      <= status.slot_free ? 4'(addr) : 4'd0;
      fired_action <= 8'd0;
      fired_object <= 8'd0;
      fired_kind   <= 3'd0;
      expired      <= 1'b0;
      last         <= 1'b1;
    end
  end

endmodule

/* sv/periodic_event_timer_table_unit.sv */
// Periodic event timer table. Each fire report of a tick is held until the next
// fire or the closing flush cycle, so the last one of a tick shows in the first cycle
// with busy low. An add scans for the lowest free slot and its result shows in the
// first cycle with busy low; remove-by-object scans every slot; remove one slot and
// remove all finish at the accepting edge. One slot per cycle from the slot memories.
// Reset clears all live bits at once; memories need no clearing. No receiver stall.
module periodic_event_timer_table_unit import pett_pkg::*; #(
  parameter int SLOTS      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // command side: a transfer happens when start is high and busy is low
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [15:0] period,
  input  logic [15:0] lifetime,
  input  logic [7:0]  action_code,
  input  logic [7:0]  object_tag,
  input  logic [2:0]  object_kind,
  input  logic        fire_at_once,
  input  logic [3:0]  slot_select,
  // result side: one transfer per cycle with strobe high
  output logic        strobe,
  output logic [1:0]  report_kind,
  output logic [3:0]  slot_id,
  output logic [7:0]  fired_action,
  output logic [7:0]  fired_object,
  output logic [2:0]  fired_kind,
  output logic        expired,
  output logic        last
);

  localparam int IDX_W = $clog2(SLOTS);

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] addr;

  // Controller: one FSM; a counter walks the slots for ticks, adds and
  // remove-by-object. A tick ends with a flush cycle so the final fire
  // report can carry the last mark.
  pett_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd),
    .addr      (addr)
  );

  // Datapath: live flags in flops, slot fields and accumulators in two
  // RAMs, one slot evaluated per cycle, one fire report held back so the
  // last one of a tick is known.
  pett_dp #(.SLOTS(SLOTS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .addr         (addr),
    .status       (status),
    .period       (period),
    .lifetime     (lifetime),
    .action_code  (action_code),
    .object_tag   (object_tag),
    .object_kind  (object_kind),
    .fire_at_once (fire_at_once),
    .slot_select  (slot_select),
    .strobe       (strobe),
    .report_kind  (report_kind),
    .slot_id      (slot_id),
    .fired_action (fired_action),
    .fired_object (fired_object),
    .fired_kind   (fired_kind),
    .expired      (expired),
    .last         (last)
  );

endmodule
